@@ sv/edsp_pkg.sv @@
// ---------------------------------------------------------------------------
// Duty setting panel package
// Shared beat types, command codes and constants for the panel controller.
// ---------------------------------------------------------------------------
`default_nettype none

package edsp_pkg;

	localparam int unsigned EDSP_QUEUE_DEPTH = 2;

	localparam logic [7:0] DUTY_STEP    = 8'd2;
	localparam logic [7:0] DUTY_MAX     = 8'hFF;
	localparam logic [7:0] DUTY_UP_TOP  = 8'hFD;
	localparam logic [7:0] BUS_MSG_LEN  = 8'd2;
	localparam logic [1:0] OUT1_MASK    = 2'b01;
	localparam logic [1:0] OUT2_MASK    = 2'b10;

	localparam int unsigned PIN_KEY_OUT2 = 0;
	localparam int unsigned PIN_KEY_OUT1 = 1;
	localparam int unsigned PIN_ENC_B    = 3;
	localparam int unsigned PIN_ENC_A    = 4;
	localparam int unsigned PIN_KEY_TGT  = 6;

	localparam int unsigned CMD_OUT1   = 0;
	localparam int unsigned CMD_OUT2   = 1;
	localparam int unsigned CMD_DUTY_A = 2;
	localparam int unsigned CMD_DUTY_B = 3;

	localparam logic FUNC_PINS = 1'b0;

	typedef struct packed {
		logic       func;
		logic [7:0] pins;
		logic [7:0] msg_length;
		logic [7:0] cmd_byte;
		logic [7:0] data_byte;
	} edsp_in_t;

	typedef struct packed {
		logic [7:0] duty_a;
		logic [7:0] duty_b;
		logic [1:0] out_bits;
		logic       target_sel;
	} edsp_out_t;

	typedef enum logic [3:0] {
		OP_NONE     = 4'd0,
		OP_STEP_UP  = 4'd1,
		OP_STEP_DN  = 4'd2,
		OP_TGT_TOG  = 4'd3,
		OP_OUT1_TOG = 4'd4,
		OP_OUT2_TOG = 4'd5,
		OP_OUT1_SET = 4'd6,
		OP_OUT2_SET = 4'd7,
		OP_DUTYA_SET = 4'd8,
		OP_DUTYB_SET = 4'd9
	} edsp_op_t;

	typedef struct packed {
		edsp_op_t   op;
		logic [7:0] data;
	} edsp_cmd_t;

endpackage

`default_nettype wire

@@ sv/encoder_duty_setting_panel_unit.sv @@
// ---------------------------------------------------------------------------
// Encoder duty setting panel unit
// Front-panel controller: encoder steps, key toggles and bus writes of two
// duty settings, a target select and two output enables.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake                   | Beat
//  ---------+-----------------------------+------------------------------
//  sample   | sample_valid / sample_stall | func, pins, msg_length, cmd, data
//  report   | report_valid / report_stall | duty_a, duty_b, out_bits, target
//
//  One sample beat per cycle is taken while sample_stall is low; each gives one
//  report beat (decode into the queue, then the settings update). The settings
//  registers, updated once per cycle unless a report stalls, set the rate.
//  A stalled report holds the back end; the queue of QueueDepth entries then
//  fills and sample_stall rises. Reset clears all settings and pin history.
// ---------------------------------------------------------------------------
`default_nettype none

module encoder_duty_setting_panel_unit #(
	parameter int unsigned QueueDepth = edsp_pkg::EDSP_QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sample_valid,
	output logic                sample_stall,
	input  wire edsp_pkg::edsp_in_t sample,
	output logic                report_valid,
	input  wire                 report_stall,
	output edsp_pkg::edsp_out_t report
);
	import edsp_pkg::*;

	logic      push;
	logic      full;
	logic      pop;
	logic      empty;
	edsp_cmd_t push_cmd;
	edsp_cmd_t pop_cmd;

	edsp_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample       (sample),
		.push         (push),
		.push_cmd     (push_cmd),
		.full         (full)
	);

	edsp_queue #(
		.Depth (QueueDepth)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.pop_cmd  (pop_cmd),
		.empty    (empty)
	);

	edsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.pop_cmd      (pop_cmd),
		.empty        (empty),
		.pop          (pop),
		.report_valid (report_valid),
		.report_stall (report_stall),
		.report       (report)
	);

endmodule

`default_nettype wire

@@ sv/edsp_front.sv @@
// ---------------------------------------------------------------------------
// Duty setting panel front end
// Accepts input beats, detects pin edges against the previous pin sample and
// decodes bus messages into one command for the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module edsp_front (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 sample_valid,
	output logic                sample_stall,
	input  wire edsp_pkg::edsp_in_t sample,
	output logic                push,
	output edsp_pkg::edsp_cmd_t push_cmd,
	input  wire                 full
);
	import edsp_pkg::*;

	logic [7:0] last_pins_q;
	logic [7:0] diff;
	edsp_op_t   op;

	assign sample_stall = full;
	assign push         = sample_valid && !full;
	assign diff         = sample.pins ^ last_pins_q;

	always_comb begin
		op = OP_NONE;
		if (sample.func == FUNC_PINS) begin
			// A change on encoder B alone still blocks the key checks below.
			priority if (diff[PIN_ENC_A]) begin
				op = (sample.pins[PIN_ENC_A] == sample.pins[PIN_ENC_B]) ?
					OP_STEP_UP : OP_STEP_DN;
			end else if (diff[PIN_ENC_B]) begin
				op = OP_NONE;
			end else if (diff[PIN_KEY_TGT] && sample.pins[PIN_KEY_TGT]) begin
				op = OP_TGT_TOG;
			end else if (diff[PIN_KEY_OUT1] && !sample.pins[PIN_KEY_OUT1]) begin
				op = OP_OUT1_TOG;
			end else if (diff[PIN_KEY_OUT2] && !sample.pins[PIN_KEY_OUT2]) begin
				op = OP_OUT2_TOG;
			end else begin
				op = OP_NONE;
			end
		end else if (sample.msg_length == BUS_MSG_LEN) begin
			priority if (sample.cmd_byte[CMD_OUT1]) begin
				op = OP_OUT1_SET;
			end else if (sample.cmd_byte[CMD_OUT2]) begin
				op = OP_OUT2_SET;
			end else if (sample.cmd_byte[CMD_DUTY_A]) begin
				op = OP_DUTYA_SET;
			end else if (sample.cmd_byte[CMD_DUTY_B]) begin
				op = OP_DUTYB_SET;
			end else begin
				op = OP_NONE;
			end
		end
	end

	assign push_cmd.op   = op;
	assign push_cmd.data = sample.data_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pins_q <= '0;
		end else if (push && sample.func == FUNC_PINS) begin
			last_pins_q <= sample.pins;
		end
	end

endmodule

`default_nettype wire

@@ sv/edsp_queue.sv @@
// ---------------------------------------------------------------------------
// Duty setting panel command queue
// Small first-in first-out store between the front end and the back end.
// ---------------------------------------------------------------------------
`default_nettype none

module edsp_queue #(
	parameter int unsigned Depth = edsp_pkg::EDSP_QUEUE_DEPTH
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  wire edsp_pkg::edsp_cmd_t push_cmd,
	output logic                full,
	input  wire                 pop,
	output edsp_pkg::edsp_cmd_t pop_cmd,
	output logic                empty
);
	import edsp_pkg::*;

	localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int unsigned CW = $clog2(Depth + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(Depth - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(Depth);

	edsp_cmd_t     mem_q [Depth];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign pop_cmd = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_IDX) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_IDX) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

@@ sv/edsp_back.sv @@
// ---------------------------------------------------------------------------
// Duty setting panel back end
// Applies queued commands to the duty, target and output registers and
// presents the resulting settings as one report beat per command.
// ---------------------------------------------------------------------------
`default_nettype none

module edsp_back (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire edsp_pkg::edsp_cmd_t pop_cmd,
	input  wire                 empty,
	output logic                pop,
	output logic                report_valid,
	input  wire                 report_stall,
	output edsp_pkg::edsp_out_t report
);
	import edsp_pkg::*;

	logic [7:0] duty_a_q;
	logic [7:0] duty_b_q;
	logic       target_q;
	logic [1:0] out_q;
	logic       report_valid_q;
	logic [7:0] sel_duty;
	logic [7:0] duty_up;
	logic [7:0] duty_dn;

	// The settings registers double as the report register: they only move
	// when the previous report beat has gone or is going.
	assign pop = !empty && (!report_valid_q || !report_stall);

	assign sel_duty = target_q ? duty_b_q : duty_a_q;
	assign duty_up  = (sel_duty > DUTY_UP_TOP) ? DUTY_MAX : sel_duty + DUTY_STEP;
	assign duty_dn  = (sel_duty < DUTY_STEP) ? '0 : sel_duty - DUTY_STEP;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_a_q       <= '0;
			duty_b_q       <= '0;
			target_q       <= 1'b0;
			out_q          <= '0;
			report_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				report_valid_q <= 1'b1;
			end else if (!report_stall) begin
				report_valid_q <= 1'b0;
			end
			if (pop) begin
				unique case (pop_cmd.op)
					OP_STEP_UP, OP_STEP_DN: begin
						if (target_q) begin
							duty_b_q <= (pop_cmd.op == OP_STEP_UP) ? duty_up : duty_dn;
						end else begin
							duty_a_q <= (pop_cmd.op == OP_STEP_UP) ? duty_up : duty_dn;
						end
					end
					OP_TGT_TOG:   target_q <= ~target_q;
					OP_OUT1_TOG:  out_q    <= out_q ^ OUT1_MASK;
					OP_OUT2_TOG:  out_q    <= out_q ^ OUT2_MASK;
					OP_OUT1_SET:  out_q    <= {out_q[1], pop_cmd.data[0]};
					OP_OUT2_SET:  out_q    <= {pop_cmd.data[0], out_q[0]};
					OP_DUTYA_SET: duty_a_q <= pop_cmd.data;
					OP_DUTYB_SET: duty_b_q <= pop_cmd.data;
					default: ;
				endcase
			end
		end
	end

	assign report_valid      = report_valid_q;
	assign report.duty_a     = duty_a_q;
	assign report.duty_b     = duty_b_q;
	assign report.out_bits   = out_q;
	assign report.target_sel = target_q;

endmodule

`default_nettype wire
